@@ sv/dqbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqbs_pkg: shared types for the double-ended queue with bag search
// Operation and status codes, and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dqbs_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VALUE_W   = 32;
  localparam int OP_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_BACK   = 3'd1,
    OP_POP_FRONT   = 3'd2,
    OP_POP_BACK    = 3'd3,
    OP_PEEK_FRONT  = 3'd4,
    OP_PEEK_BACK   = 3'd5,
    OP_CONTAINS    = 3'd6,
    OP_REMOVE      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OFF_ZERO = 2'd0,
    OFF_LAST = 2'd1,
    OFF_IDX  = 2'd2
  } off_sel_t;

  typedef struct packed {
    logic     accept;
    status_t  st;
    logic     push_front;
    logic     push_back;
    logic     rd_en;
    off_sel_t rd_off;
    logic     idx_clr;
    logic     idx_inc;
    logic     shift_wr;
    logic     pop_front;
    logic     pop_back;
    logic     take_rd;
    logic     set_found;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic idx_lt_cnt;
    logic match;
  } dp_sts_t;

endpackage

@@ sv/deque_with_bag_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_bag_search_top: bounded double-ended queue with bag search
// Send one request word on the in_ channel: the operation code in in_tuser,
// the operand in in_tdata. Every request returns exactly one result word on
// the out_ channel: read value, found flag, entry count and status.
// One request is in flight at a time; in_tready is high only while idle.
// The scan reads the entry memory's single read port once per cycle and the
// gap closing streams one entry per cycle behind it.
// The result sits in an output register; the next request is accepted
// while it waits, and the block holds its own finished result until the
// receiver takes the previous one.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module deque_with_bag_search_top #(
  parameter int DEPTH = dqbs_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int OUT_W = ((dqbs_pkg::VALUE_W + 3 + CW + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [dqbs_pkg::VALUE_W-1:0] in_tdata,   // value
  input  logic [dqbs_pkg::OP_W-1:0]    in_tuser,   // command
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [OUT_W-1:0]             out_tdata   // read_value, found, entry_count, status
);
  import dqbs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dqbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dqbs_dp #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .OUT_W (OUT_W)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule

@@ sv/dqbs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqbs_dp: datapath of the double-ended queue with bag search
// Entry ring memory, head and count registers, scan index, result and
// output word registers.
// ----------------------------------------------------------------------------
module dqbs_dp #(
  parameter int DEPTH = dqbs_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int OUT_W = ((dqbs_pkg::VALUE_W + 3 + CW + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [dqbs_pkg::VALUE_W-1:0] in_value,
  input  dqbs_pkg::dp_cmd_t            cmd,
  output dqbs_pkg::dp_sts_t            sts,
  output logic [OUT_W-1:0]             out_data
);
  import dqbs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

  logic [VALUE_W-1:0] mem_r [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;
  logic [VALUE_W-1:0] val_r;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [VALUE_W-1:0] res_val_r;
  logic               res_found_r;
  status_t            res_st_r;
  logic [OUT_W-1:0]   out_data_r;

  logic [CW-1:0]      rd_off;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               wr_en;

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(off);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    case (cmd.rd_off)
      OFF_ZERO: rd_off = '0;
      OFF_LAST: rd_off = count_r - CW'(1);
      OFF_IDX:  rd_off = idx_r;
      default:  rd_off = '0;
    endcase
  end

  assign rd_addr = ring_pos(head_r, rd_off);

  always_comb begin
    wr_en   = cmd.push_front | cmd.push_back | cmd.shift_wr;
    wr_data = in_value;
    wr_addr = ring_pos(head_r, count_r);
    if (cmd.push_front) begin
      wr_addr = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
    end else if (cmd.shift_wr) begin
      wr_addr = ring_pos(head_r, idx_r - CW'(2));
      wr_data = rd_data_r;
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.push_front) begin
      head_nxt  = wr_addr;
      count_nxt = count_r + CW'(1);
    end else if (cmd.push_back) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_front) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end else if (cmd.pop_back) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r       <= in_value;
      res_val_r   <= '0;
      res_found_r <= 1'b0;
      res_st_r    <= cmd.st;
    end else begin
      if (cmd.take_rd) begin
        res_val_r <= rd_data_r;
      end
      if (cmd.set_found) begin
        res_found_r <= 1'b1;
      end
    end
    if (cmd.emit) begin
      out_data_r <= OUT_W'({res_st_r, count_r, res_found_r, res_val_r});
    end
  end

  assign sts.cnt_zero   = (count_r == '0);
  assign sts.cnt_full   = (count_r == CW'(DEPTH));
  assign sts.idx_lt_cnt = (idx_r < count_r);
  assign sts.match      = (rd_data_r == val_r);
  assign out_data       = out_data_r;

endmodule

@@ sv/dqbs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqbs_ctrl: controller of the double-ended queue with bag search
// Sequences each request through push, end read, scan and gap closing,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module dqbs_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [dqbs_pkg::OP_W-1:0] in_op,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  dqbs_pkg::dp_sts_t         sts,
  output dqbs_pkg::dp_cmd_t         cmd
);
  import dqbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt, op_in;
  logic   pend_r, pend_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   issue;

  assign op_in     = op_t'(in_op);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.st        = ST_OK;
    cmd.rd_off    = OFF_IDX;
    state_nxt     = state_r;
    op_nxt        = op_r;
    pend_nxt      = pend_r;
    issue         = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          op_nxt     = op_in;
          state_nxt  = S_RESP;
          if (op_in inside {OP_PUSH_FRONT, OP_PUSH_BACK}) begin
            if (sts.cnt_full) begin
              cmd.st = ST_FULL;
            end else begin
              cmd.push_front = (op_in == OP_PUSH_FRONT);
              cmd.push_back  = (op_in == OP_PUSH_BACK);
            end
          end else if (sts.cnt_zero) begin
            cmd.st = ST_EMPTY;
          end else if (op_in inside {OP_CONTAINS, OP_REMOVE}) begin
            cmd.idx_clr = 1'b1;
            pend_nxt    = 1'b0;
            state_nxt   = S_SCAN;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_off = (op_in inside {OP_POP_FRONT, OP_PEEK_FRONT}) ? OFF_ZERO : OFF_LAST;
            state_nxt  = S_TAKE;
          end
        end
      end
      S_TAKE: begin
        cmd.take_rd   = 1'b1;
        cmd.pop_front = (op_r == OP_POP_FRONT);
        cmd.pop_back  = (op_r == OP_POP_BACK);
        state_nxt     = S_RESP;
      end
      S_SCAN: begin
        issue       = sts.idx_lt_cnt & ~(pend_r & sts.match);
        cmd.rd_en   = issue;
        cmd.idx_inc = issue;
        pend_nxt    = issue;
        if (pend_r && sts.match) begin
          cmd.set_found = 1'b1;
          state_nxt     = (op_r == OP_REMOVE) ? S_SHIFT : S_RESP;
        end else if (!issue && !pend_r) begin
          state_nxt = S_RESP;
        end
      end
      S_SHIFT: begin
        issue        = sts.idx_lt_cnt;
        cmd.rd_en    = issue;
        cmd.idx_inc  = issue;
        cmd.shift_wr = pend_r;
        pend_nxt     = issue;
        if (!issue && !pend_r) begin
          cmd.pop_back = 1'b1;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_PUSH_FRONT;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
